### hw/rtl/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, constants and the sRGB threshold builder for the linear float
// to sRGB8 pixel converter.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
  localparam int unsigned NUM_STG  = 4;
  localparam int unsigned NUM_THR  = 255;

  typedef struct packed {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic [31:0] alpha_bits;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_code;
    logic [7:0] green_code;
    logic [7:0] blue_code;
    logic [7:0] alpha_code;
  } pix_out_t;

  // per-stage load enables and occupancy, index 0 is the first register stage
  typedef struct packed {
    logic [NUM_STG-1:0] en;
    logic [NUM_STG-1:0] vld;
  } lfs_adv_t;

  // smallest saturated pattern whose exact encoded value reaches (k-0.5)/255,
  // worked out in exact integer arithmetic at elaboration
  function automatic logic [31:0] thr_calc(input int unsigned k);
    logic [1023:0] b12;
    logic [1023:0] rb;
    logic [1023:0] lhs;
    logic [1023:0] rhs;
    logic [31:0]   lo;
    logic [31:0]   hi;
    logic [31:0]   mid;
    logic [31:0]   m;
    logic [63:0]   l64;
    logic [63:0]   r64;
    int unsigned   s;
    int unsigned   i;
    logic          ok;
    b12 = 1024'd1;
    rb  = 1024'd1;
    for (i = 0; i < 12; i++) begin
      b12 = b12 * 1024'd10761;
      rb  = rb * 1024'(40 * k + 541);
    end
    lo = 32'd0;
    hi = ONE_BITS;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (mid[30:23] == 8'd0) begin
        m = {9'd0, mid[22:0]};
        s = 149;
      end else begin
        m = {8'd0, 1'b1, mid[22:0]};
        s = 150 - int'(mid[30:23]);
      end
      if (m == 32'd0) begin
        ok = 1'b0;
      end else if (k <= 10) begin
        if (s >= 40) begin
          ok = 1'b0;
        end else begin
          l64 = 64'(m) * 64'd32946;
          r64 = 64'(5 * (2 * k - 1)) << s;
          ok  = (l64 >= r64);
        end
      end else begin
        lhs = b12;
        for (i = 0; i < 5; i++) begin
          lhs = lhs * 1024'(m);
        end
        rhs = rb << (5 * s);
        ok  = (lhs >= rhs);
      end
      if (ok) begin
        hi = mid;
      end else begin
        lo = mid + 32'd1;
      end
    end
    return lo;
  endfunction

endpackage

### hw/rtl/lfs_ctrl.sv
// ----------------------------------------------------------------------------
// lfs_ctrl
// Valid tracking and stage enables for the four-stage pixel pipeline.
// ----------------------------------------------------------------------------
module lfs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lfs_pkg::lfs_adv_t adv_o
);
  import lfs_pkg::*;

  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] vld_d;
  logic [NUM_STG-1:0] en;
  logic               in_acc;
  logic               out_acc;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NUM_STG-1] = !vld_q[NUM_STG-1] || !out_stall_i;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < NUM_STG; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NUM_STG-1];
  assign adv_o.en    = en;
  assign adv_o.vld   = vld_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // back pressure reaches the input only with every stage occupied
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  // items in flight change only by transfers at the two ends
  a_conserve : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(vld_q) ==
              $past($countones(vld_q)) + $past(int'(in_acc)) - $past(int'(out_acc))))
    else $error("pipeline item count mismatch");

endmodule

### hw/rtl/lfs_color.sv
// ----------------------------------------------------------------------------
// lfs_color
// sRGB encode of red, green and blue: threshold compare, code encode and
// output register.
// ----------------------------------------------------------------------------
module lfs_color (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lfs_pkg::lfs_adv_t      adv_i,
  input  logic [2:0][31:0]       sat_i,
  output logic [2:0][7:0]        code_o
);
  import lfs_pkg::*;

  logic [2:0][NUM_THR-1:0] ge;
  logic [2:0][NUM_THR-1:0] therm_q;
  logic [2:0][7:0]         code_d;
  logic [2:0][7:0]         code3_q;
  logic [2:0][7:0]         code_q;

  // bit k set when the saturated pattern reaches code k+1
  for (genvar k = 0; k < NUM_THR; k++) begin : g_thr
    localparam logic [31:0] Thr = thr_calc(k + 1);
    for (genvar c = 0; c < 3; c++) begin : g_ch
      assign ge[c][k] = (sat_i[c] >= Thr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[1]) begin
      therm_q <= ge;
    end
  end

  // binary search of the thermometer, one code bit a step
  always_comb begin : p_enc
    logic [7:0] acc;
    logic [7:0] cand;
    for (int c = 0; c < 3; c++) begin
      acc = 8'd0;
      for (int b = 7; b >= 0; b--) begin
        cand = acc | (8'd1 << b);
        if (therm_q[c][cand - 8'd1]) begin
          acc = cand;
        end
      end
      code_d[c] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[2]) begin
      code3_q <= code_d;
    end
    if (adv_i.en[3]) begin
      code_q <= code3_q;
    end
  end

  assign code_o = code_q;

  // thresholds rise with the code, so the compare result is a thermometer
  a_therm_red : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i.vld[1] |-> ((therm_q[2] & (therm_q[2] + 255'd1)) == '0))
    else $error("red compare vector is not a thermometer");

endmodule

### hw/rtl/lfs_alpha.sv
// ----------------------------------------------------------------------------
// lfs_alpha
// Alpha times 255: multiply, round to single precision, round to code.
// ----------------------------------------------------------------------------
module lfs_alpha (
  input  logic              clk_i,
  input  lfs_pkg::lfs_adv_t adv_i,
  input  logic [31:0]       sat_i,
  output logic [7:0]        code_o
);
  import lfs_pkg::*;

  logic [7:0]  e;
  logic [23:0] m;
  logic [8:0]  s9;
  logic [31:0] p_d;
  logic        nz_d;
  logic [31:0] p_q;
  logic [5:0]  s2_q;
  logic        nz2_q;

  logic [24:0] keep;
  logic [24:0] keep_r;
  logic        up;
  logic [32:0] pr_d;
  logic [32:0] pr_q;
  logic [5:0]  s3_q;
  logic        nz3_q;

  logic [33:0] sum;
  logic [33:0] shifted;
  logic [7:0]  code_d;
  logic [7:0]  code_q;

  // stage 2: mantissa times 255, only scales below 34 can give a nonzero code
  always_comb begin
    e    = sat_i[30:23];
    m    = (e == 8'd0) ? {1'b0, sat_i[22:0]} : {1'b1, sat_i[22:0]};
    s9   = 9'd150 - {1'b0, e};
    p_d  = ({8'd0, m} << 8) - {8'd0, m};
    nz_d = (e != 8'd0) && (s9 < 9'd34);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[1]) begin
      p_q   <= p_d;
      s2_q  <= s9[5:0];
      nz2_q <= nz_d;
    end
  end

  // stage 3: keep 24 significant bits, nearest with ties to even
  always_comb begin
    if (p_q[31]) begin
      keep   = {1'b0, p_q[31:8]};
      up     = (p_q[7:0] > 8'h80) || ((p_q[7:0] == 8'h80) && keep[0]);
      keep_r = keep + {24'd0, up};
      pr_d   = {keep_r, 8'd0};
    end else begin
      keep   = {1'b0, p_q[30:7]};
      up     = (p_q[6:0] > 7'h40) || ((p_q[6:0] == 7'h40) && keep[0]);
      keep_r = keep + {24'd0, up};
      pr_d   = {1'b0, keep_r, 7'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[2]) begin
      pr_q  <= pr_d;
      s3_q  <= s2_q;
      nz3_q <= nz2_q;
    end
  end

  // stage 4: add half an lsb at the scale and drop the fraction
  always_comb begin
    sum     = {1'b0, pr_q} + (34'd1 << (s3_q - 6'd1));
    shifted = sum >> s3_q;
    code_d  = nz3_q ? shifted[7:0] : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[3]) begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

endmodule

### hw/rtl/linear_float_to_srgb8_pixel_top.sv
// ----------------------------------------------------------------------------
// linear_float_to_srgb8_pixel_top
// Converts one RGBA pixel of single-precision linear components to 8-bit
// sRGB codes with linear alpha.
// ----------------------------------------------------------------------------
// Takes one pixel per clock when not stalled and returns its codes through
// its stages: saturate, threshold compare and alpha multiply, code encode
// and alpha rounding, then the output register. The four stages advance
// independently, so a stall at the output holds only the stages behind a
// full one, and the input stalls only when every stage is occupied. Color
// codes come from 255 constant thresholds per channel built at elaboration.
module linear_float_to_srgb8_pixel_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lfs_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lfs_pkg::pix_out_t out_data_o
);
  import lfs_pkg::*;

  lfs_adv_t        adv;
  pix_in_t         sat_d;
  pix_in_t         sat_q;
  logic [2:0][7:0] col_code;
  logic [7:0]      alp_code;

  // NaN and negatives go to zero, anything above one to one
  function automatic logic [31:0] sat_bits(input logic [31:0] b);
    logic [31:0] r;
    if (b[31]) begin
      r = 32'd0;
    end else if ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) begin
      r = 32'd0;
    end else if (b > ONE_BITS) begin
      r = ONE_BITS;
    end else begin
      r = b;
    end
    return r;
  endfunction

  always_comb begin
    sat_d.red_bits   = sat_bits(in_data_i.red_bits);
    sat_d.green_bits = sat_bits(in_data_i.green_bits);
    sat_d.blue_bits  = sat_bits(in_data_i.blue_bits);
    sat_d.alpha_bits = sat_bits(in_data_i.alpha_bits);
  end

  always_ff @(posedge clk_i) begin
    if (adv.en[0]) begin
      sat_q <= sat_d;
    end
  end

  lfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .adv_o       (adv)
  );

  lfs_color u_color (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .sat_i  ({sat_q.red_bits, sat_q.green_bits, sat_q.blue_bits}),
    .code_o (col_code)
  );

  lfs_alpha u_alpha (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .sat_i  (sat_q.alpha_bits),
    .code_o (alp_code)
  );

  assign out_data_o.red_code   = col_code[2];
  assign out_data_o.green_code = col_code[1];
  assign out_data_o.blue_code  = col_code[0];
  assign out_data_o.alpha_code = alp_code;

endmodule

### tb/sv/tb_linear_float_to_srgb8_pixel_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_float_to_srgb8_pixel_top
// Drives RGBA single-precision pixels into the converter and checks every
// output transfer against a bit-exact predictor, or against the codes given
// in the directed table for typed rows. The predictor finds each color code
// by a search over the code range, using exact integer comparisons against
// the published sRGB curve. Alpha is predicted as a rounded single-precision
// multiply by 255. A short table of directed pixels comes first. Random
// pixels follow in four phases of sender gap and receiver stall settings.
// ----------------------------------------------------------------------------
module tb_linear_float_to_srgb8_pixel_top;
  import lfs_pkg::*;

  localparam int unsigned PHASE_PIXELS = 413;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    pix_in_t  px;
    logic     typed;
    pix_out_t want;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  pix_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pix_out_t out_data_o;

  // 10761^12 and (40k+541)^12, the two sides of the exact curve compare
  logic [383:0] curve_scale;
  logic [383:0] knee_pow [0:255];

  dir_row_t    dir_rows[$];
  pix_out_t    codes_due[$];
  pix_out_t    next_codes;
  pix_out_t    head_codes;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  linear_float_to_srgb8_pixel_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] clamp_unit(input logic [31:0] b);
    if (b[31]) return 32'd0;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) return 32'd0;
    if (b > ONE_BITS) return ONE_BITS;
    return b;
  endfunction

  function automatic logic [31:0] float_mant(input logic [31:0] b);
    if (b[30:23] == 8'd0) return {9'd0, b[22:0]};
    return {8'd0, 1'b1, b[22:0]};
  endfunction

  function automatic int unsigned float_scale(input logic [31:0] b);
    if (b[30:23] == 8'd0) return 149;
    return 150 - int'(b[30:23]);
  endfunction

  // true when m * 2^-s encodes to at least (k-0.5)/255
  function automatic bit code_reached(input logic [31:0] mant, input int unsigned scale,
                                      input logic [383:0] mant_term, input int unsigned k);
    logic [63:0] lin_l;
    logic [63:0] lin_r;
    if (mant == 32'd0) return 1'b0;
    if (k == 0) return 1'b1;
    if (k <= 10) begin
      if (scale >= 40) return 1'b0;
      lin_l = 64'(mant);
      lin_l = lin_l * 64'd32946;
      lin_r = 64'(5 * (2 * k - 1));
      lin_r = lin_r << scale;
      return lin_l >= lin_r;
    end
    // anything this small is far below the first curved code
    if (scale > 40) return 1'b0;
    return mant_term >= (knee_pow[k] << (5 * scale));
  endfunction

  function automatic logic [7:0] srgb_code(input logic [31:0] sat);
    logic [31:0]  mant;
    int unsigned  scale;
    logic [383:0] wide_m;
    logic [383:0] term;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    mant   = float_mant(sat);
    scale  = float_scale(sat);
    wide_m = 384'(mant);
    term   = curve_scale;
    repeat (5) term = term * wide_m;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (code_reached(mant, scale, term, mid)) lo = mid;
      else hi = mid - 1;
    end
    return lo[7:0];
  endfunction

  function automatic logic [7:0] coverage_code(input logic [31:0] sat);
    logic [31:0] mant;
    int unsigned scale;
    int unsigned n;
    int unsigned d;
    logic [63:0] prod;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    mant  = float_mant(sat);
    scale = float_scale(sat);
    prod  = 64'(mant);
    prod  = prod * 64'd255;
    n = 0;
    while (n < 40 && (prod >> n) != 64'd0) n++;
    // round the product to 24 significant bits, ties to even
    if (n > 24) begin
      d    = n - 24;
      keep = prod >> d;
      rem  = prod & ((64'd1 << d) - 64'd1);
      half = 64'd1 << (d - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      prod = keep << d;
    end
    if (scale >= 34) return 8'd0;
    prod = (prod + (64'd1 << (scale - 1))) >> scale;
    return prod[7:0];
  endfunction

  function automatic pix_out_t predict_pixel(input pix_in_t px);
    pix_out_t r;
    r.red_code   = srgb_code(clamp_unit(px.red_bits));
    r.green_code = srgb_code(clamp_unit(px.green_bits));
    r.blue_code  = srgb_code(clamp_unit(px.blue_bits));
    r.alpha_code = coverage_code(clamp_unit(px.alpha_bits));
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] random_component();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom_range(0, ONE_BITS);
    if (sel < 70) return $urandom_range(32'h3B00_0000, ONE_BITS);
    if (sel < 85) return $urandom_range(0, 32'h3B80_0000);
    return $urandom();
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    px.red_bits   = random_component();
    px.green_bits = random_component();
    px.blue_bits  = random_component();
    px.alpha_bits = random_component();
    return px;
  endfunction

  task automatic add_row(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b,
                         input logic [31:0] a, input logic typed, input logic [7:0] code);
    dir_rows.push_back({r, g, b, a, typed, code, code, code, code});
  endtask

  task automatic add_mixed_row();
    // one, zero, nan and minus one side by side
    dir_rows.push_back({ONE_BITS, 32'h0000_0000, 32'h7FC0_0000, 32'hBF80_0000,
                        1'b1, 8'd255, 8'd0, 8'd0, 8'd0});
  endtask

  // entered just after a falling edge, returns just after one
  task automatic send_pixel(input pix_in_t px, input logic typed, input pix_out_t want);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    next_codes = typed ? want : predict_pixel(px);
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: expected %0d, got %0d", results_seen, what,
               exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               codes_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // the oldest pending pixel is matched before this edge's input is queued
      if (out_valid_o && !out_stall_i) begin
        if (codes_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("output transfer %0d with no pixel pending", results_seen);
        end else begin
          head_codes = codes_due.pop_front();
          if (out_data_o.red_code !== head_codes.red_code)
            flag_mismatch("red_code", head_codes.red_code, out_data_o.red_code);
          if (out_data_o.green_code !== head_codes.green_code)
            flag_mismatch("green_code", head_codes.green_code, out_data_o.green_code);
          if (out_data_o.blue_code !== head_codes.blue_code)
            flag_mismatch("blue_code", head_codes.blue_code, out_data_o.blue_code);
          if (out_data_o.alpha_code !== head_codes.alpha_code)
            flag_mismatch("alpha_code", head_codes.alpha_code, out_data_o.alpha_code);
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        codes_due.push_back(next_codes);
        pixels_sent++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned k;
    int unsigned i;
    int unsigned ph;
    int unsigned n;
    logic [383:0] base;
    dir_row_t row;

    curve_scale = 384'd1;
    for (i = 0; i < 12; i++) curve_scale = curve_scale * 384'd10761;
    for (k = 0; k < 256; k++) begin
      base        = 384'(40 * k + 541);
      knee_pow[k] = 384'd1;
      for (i = 0; i < 12; i++) knee_pow[k] = knee_pow[k] * base;
    end

    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 8'd0);
    add_row(ONE_BITS, ONE_BITS, ONE_BITS, ONE_BITS, 1'b1, 8'd255);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 8'd0);
    add_row(32'h7FC0_0000, 32'hFFC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 1'b1, 8'd0);
    add_row(32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b1, 8'd255);
    add_row(32'hFF80_0000, 32'hBF80_0000, 32'h8000_0001, 32'hFF7F_FFFF, 1'b1, 8'd0);
    add_row(32'h7F7F_FFFF, 32'h3F80_0001, 32'h4000_0000, 32'h4B00_0000, 1'b1, 8'd255);
    add_row(32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h0000_0002, 1'b1, 8'd0);
    add_row(32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 1'b1, 8'd0);
    add_mixed_row();
    // around the knee of the curve
    add_row(32'h3B4D_2E1C, 32'h3B4D_2E1B, 32'h3B4D_2E1D, 32'h3F00_0000, 1'b0, 8'd0);
    add_row(32'h3F00_0000, 32'h3F00_0000, 32'h3F00_0000, 32'h3F00_0000, 1'b0, 8'd0);
    add_row(32'h3F7F_FFFF, 32'h3F7F_FFFE, 32'h3F7F_FF00, 32'h3F7F_FFFF, 1'b0, 8'd0);
    add_row(32'h3E80_0000, 32'h3F40_0000, 32'h3DCC_CCCD, 32'h3C23_D70A, 1'b0, 8'd0);
    // alpha near half a code step
    add_row(32'h3B00_8081, 32'h3BC0_C0C1, 32'h3B00_8080, 32'h3B00_8081, 1'b0, 8'd0);
    add_row(32'h3BC0_C0C1, 32'h3B00_8080, 32'h3C00_0000, 32'h3BC0_C0C1, 1'b0, 8'd0);
    add_row(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h3A5A_5A5A, 32'h3E5A_5A5A, 1'b0, 8'd0);
    add_row(32'h00FF_FFFF, 32'h3F7F_0000, 32'h3900_0000, 32'h3A80_0000, 1'b0, 8'd0);
    add_row(32'h3B80_0000, 32'h3B40_0000, 32'h3D00_0000, 32'h3F7F_8000, 1'b0, 8'd0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[j]) begin
      row = dir_rows[j];
      send_pixel(row.px, row.typed, row.want);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 65;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 65;
        end
        default: begin
          gap_pct   = 7;
          stall_pct = 7;
        end
      endcase
      for (n = 0; n < PHASE_PIXELS; n++) send_pixel(random_pixel(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (codes_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d pixels sent (%0d from the directed table), %0d results checked",
             pixels_sent, dir_rows.size(), results_seen);
    $display("phases: free running, sender gaps, receiver stalls, light mix; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
